// ===== rtl/hwpc_pkg.sv =====
// Shared types and constants for the host watchdog and power-cycle supervisor.
// No dependencies; the regs, core, top level and testbench import this package.
`default_nettype none

package hwpc_pkg;

    // item kinds carried in the kind field of an input beat
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_DELAY = 2'd2,
        KIND_COUNT = 2'd3
    } t_kind;

    // host command codes, compared on all 16 bits
    localparam logic [15:0] CMD_CLEAR = 16'h0001;
    localparam logic [15:0] CMD_RESET = 16'h0011;
    localparam logic [15:0] CMD_CYCLE = 16'h0021;

    localparam logic [15:0] MIN_LIMIT       = 16'd300;
    localparam logic [7:0]  DEFAULT_DELAY   = 8'd30;
    localparam logic [7:0]  DEFAULT_TIMEOUT = 8'd30;
    localparam logic [7:0]  DELAY_MAX       = 8'hFF;

    // configuration register map: register select is paddr[2]
    localparam int          CFG_ADDR_BITS     = 3;
    localparam logic        REG_ELAPSED_LIMIT = 1'b0;
    localparam logic        REG_ERROR_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [15:0] elapsed_limit;
        logic [7:0]  error_timeout;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic        bus_error;
    } t_item;

    typedef struct packed {
        logic        shutdown;
        logic        soft_reset;
        logic [15:0] elapsed_now;
        logic        cycle_pending;
        logic [7:0]  cycle_remaining;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/hwpc_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
// Depends on nothing; payload widths follow the package field layout.
`default_nettype none

interface hwpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        bus_error;

    modport source (output valid, output kind, output value, output bus_error, input ready);
    modport sink   (input valid, input kind, input value, input bus_error, output ready);
endinterface

interface hwpc_out_if;
    logic        valid;
    logic        ready;
    logic        shutdown;
    logic        soft_reset;
    logic [15:0] elapsed_now;
    logic        cycle_pending;
    logic [7:0]  cycle_remaining;

    modport source (output valid, output shutdown, output soft_reset, output elapsed_now,
                    output cycle_pending, output cycle_remaining, input ready);
    modport sink   (input valid, input shutdown, input soft_reset, input elapsed_now,
                    input cycle_pending, input cycle_remaining, output ready);
endinterface

`default_nettype wire

// ===== rtl/hwpc_regs.sv =====
// APB-style configuration registers: elapsed limit and bus-error timeout.
// Depends on hwpc_pkg for the register map and the t_cfg type.
`default_nettype none

module hwpc_regs
    import hwpc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    logic [15:0] r_elapsed_limit;
    logic [7:0]  r_error_timeout;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed_limit <= MIN_LIMIT;
            r_error_timeout <= DEFAULT_TIMEOUT;
        end else if (wr_en) begin
            case (paddr[2])
                REG_ELAPSED_LIMIT: r_elapsed_limit <= pwdata[15:0];
                REG_ERROR_TIMEOUT: r_error_timeout <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (paddr[2])
            REG_ELAPSED_LIMIT: prdata = {16'd0, r_elapsed_limit};
            REG_ERROR_TIMEOUT: prdata = {24'd0, r_error_timeout};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg.elapsed_limit = r_elapsed_limit;
    assign o_cfg.error_timeout = r_error_timeout;

endmodule

`default_nettype wire

// ===== rtl/hwpc_core.sv =====
// Supervisor state and single-pass update for one item: elapsed counter,
// cycle countdown, bus-error countdown and soft reset. Depends on hwpc_pkg.
`default_nettype none

module hwpc_core
    import hwpc_pkg::*;
#(
    parameter int ELAPSED_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    localparam int CW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    logic [ELAPSED_BITS-1:0] r_elapsed, n_elapsed;
    logic                    r_cycle_req, n_cycle_req;
    logic [7:0]              r_cycle_count, n_cycle_count;
    logic [7:0]              r_error_count, n_error_count;
    logic [7:0]              r_cycle_delay, n_cycle_delay;
    logic                    r_shutdown, n_shutdown;

    logic [15:0]             eff_limit;
    logic                    at_limit;
    logic [ELAPSED_BITS-1:0] count_wr;
    logic [7:0]              delay_wr;
    logic [7:0]              err_dec;
    logic                    reset_now;

    // effective limit and write saturation
    assign eff_limit = (i_cfg.elapsed_limit < MIN_LIMIT) ? MIN_LIMIT : i_cfg.elapsed_limit;
    assign at_limit  = CW'(r_elapsed) >= CW'(eff_limit);
    assign count_wr  = (CW'(i_item.value) > CW'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                               : ELAPSED_BITS'(i_item.value);
    assign delay_wr  = (i_item.value > 16'(DELAY_MAX)) ? DELAY_MAX : i_item.value[7:0];
    assign err_dec   = (r_error_count != 8'd0) ? r_error_count - 8'd1 : 8'd0;

    // next state: tick order is elapsed check, cycle countdown, bus-error check
    always_comb begin
        n_elapsed     = r_elapsed;
        n_cycle_req   = r_cycle_req;
        n_cycle_count = r_cycle_count;
        n_error_count = r_error_count;
        n_cycle_delay = r_cycle_delay;
        n_shutdown    = r_shutdown;
        reset_now     = 1'b0;
        case (i_item.kind)
            KIND_TICK: begin
                if (at_limit) begin
                    n_cycle_req   = 1'b1;
                    n_cycle_count = 8'd0;
                end else if (r_elapsed != ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                if (n_cycle_req) begin
                    if (n_cycle_count != 8'd0) begin
                        n_cycle_count = n_cycle_count - 8'd1;
                    end else begin
                        n_shutdown = 1'b1;
                    end
                end
                if (i_item.bus_error) begin
                    n_error_count = err_dec;
                    reset_now     = (err_dec == 8'd0);
                end else begin
                    n_error_count = i_cfg.error_timeout;
                end
            end
            KIND_CMD: begin
                if (i_item.value == CMD_CLEAR) begin
                    n_elapsed = '0;
                end else if (i_item.value == CMD_RESET) begin
                    reset_now = 1'b1;
                end else if (i_item.value == CMD_CYCLE) begin
                    n_cycle_req   = 1'b1;
                    n_cycle_count = r_cycle_delay;
                end
            end
            KIND_DELAY: n_cycle_delay = delay_wr;
            KIND_COUNT: n_elapsed     = count_wr;
            default: ;
        endcase
        // soft reset restores defaults, error count from cfg, regs untouched
        if (reset_now) begin
            n_elapsed     = '0;
            n_cycle_req   = 1'b0;
            n_cycle_count = 8'd0;
            n_error_count = i_cfg.error_timeout;
            n_cycle_delay = DEFAULT_DELAY;
            n_shutdown    = 1'b0;
        end
    end

    // result reflects the state after the item
    always_comb begin
        o_result.shutdown        = n_shutdown;
        o_result.soft_reset      = reset_now;
        o_result.elapsed_now     = 16'(n_elapsed);
        o_result.cycle_pending   = n_cycle_req;
        o_result.cycle_remaining = n_cycle_count;
    end

    // state registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed     <= '0;
            r_cycle_req   <= 1'b0;
            r_cycle_count <= 8'd0;
            r_error_count <= DEFAULT_TIMEOUT;
            r_cycle_delay <= DEFAULT_DELAY;
            r_shutdown    <= 1'b0;
        end else if (i_step) begin
            r_elapsed     <= n_elapsed;
            r_cycle_req   <= n_cycle_req;
            r_cycle_count <= n_cycle_count;
            r_error_count <= n_error_count;
            r_cycle_delay <= n_cycle_delay;
            r_shutdown    <= n_shutdown;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/host_watchdog_power_cycler.sv =====
// Top level of the host watchdog and power-cycle supervisor.
// Depends on hwpc_pkg, hwpc_if, hwpc_regs and hwpc_core.
//
// Usage
//   i_item carries one event per beat: a one-second tick (with the bus-error
//   sample), a host command, a delay write or an elapsed counter write.
//   o_result returns exactly one beat per input beat, in order, showing the
//   shutdown line, the soft-reset strobe, the elapsed counter, the pending
//   cycle flag and the seconds left in the pending countdown.
//   The APB port holds elapsed_limit (0x0) and error_timeout (0x4); write it
//   only while no beat is in flight. pready is always high.
// Timing
//   An accepted beat is held in the input register, is evaluated in a
//   single combinational pass and lands in the result register, which drives
//   o_result.valid. One beat per cycle is sustained while the receiver keeps
//   ready high; the single-pass update of the supervisor state sets that rate.
// Reset and stall
//   A synchronous reset empties both stages and returns the state to the
//   reset values (limit 300, timeout 30, delay 30). While the receiver holds
//   ready low the result beat is held and one more beat is taken into the
//   input register; after that i_item.ready drops until the result moves.
`default_nettype none

module host_watchdog_power_cycler
    import hwpc_pkg::*;
#(
    parameter int ELAPSED_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    hwpc_in_if.sink                       i_item,
    hwpc_out_if.source                    o_result
);

    t_cfg    cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out_res;
    logic    r_out_valid;
    t_result core_res;
    logic    advance;
    logic    step;
    logic    in_accept;

    hwpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hwpc_core #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // handshake: result stage frees when empty or taken
    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;
    assign in_accept    = i_item.valid && i_item.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.kind      <= t_kind'(i_item.kind);
            r_in_item.value     <= i_item.value;
            r_in_item.bus_error <= i_item.bus_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.shutdown        = r_out_res.shutdown;
    assign o_result.soft_reset      = r_out_res.soft_reset;
    assign o_result.elapsed_now     = r_out_res.elapsed_now;
    assign o_result.cycle_pending   = r_out_res.cycle_pending;
    assign o_result.cycle_remaining = r_out_res.cycle_remaining;

endmodule

`default_nettype wire

// ===== rtl/hwpc_checker.sv =====
// Port-level checks on the result channel of the supervisor, bound to the top.
// Depends on the top level host_watchdog_power_cycler port names.
`default_nettype none

module hwpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_shutdown,
    input wire logic        i_soft_reset,
    input wire logic [15:0] i_elapsed_now,
    input wire logic        i_cycle_pending,
    input wire logic [7:0]  i_cycle_remaining
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_shutdown, i_soft_reset, i_elapsed_now,
                                                    i_cycle_pending, i_cycle_remaining}))
        else $error("result beat changed while stalled");

    // a soft reset beat shows cleared state
    a_soft_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_soft_reset |-> !i_shutdown && !i_cycle_pending
                                    && i_elapsed_now == 16'd0 && i_cycle_remaining == 8'd0)
        else $error("soft reset beat with live state");

    // countdown only runs for a requested cycle
    a_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_cycle_remaining != 8'd0 |-> i_cycle_pending)
        else $error("countdown without pending cycle");

    // shutdown only follows a requested cycle
    a_shutdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_shutdown |-> i_cycle_pending)
        else $error("shutdown without pending cycle");

endmodule

bind host_watchdog_power_cycler hwpc_checker u_hwpc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_result.valid),
    .i_ready           (o_result.ready),
    .i_shutdown        (o_result.shutdown),
    .i_soft_reset      (o_result.soft_reset),
    .i_elapsed_now     (o_result.elapsed_now),
    .i_cycle_pending   (o_result.cycle_pending),
    .i_cycle_remaining (o_result.cycle_remaining)
);

`default_nettype wire

// ===== test/host_watchdog_power_cycler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for host_watchdog_power_cycler: random and directed beats with a
// scoreboard that predicts every result beat. Depends on hwpc_pkg, hwpc_if and the rtl.

module host_watchdog_power_cycler_tb;
    import hwpc_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_BEATS = 138;
    localparam int NUM_PHASES   = 8;
    localparam int TAIL_CYCLES  = 8;
    localparam logic [CFG_ADDR_BITS-1:0] LIMIT_ADDR   = {REG_ELAPSED_LIMIT, 2'b00};
    localparam logic [CFG_ADDR_BITS-1:0] TIMEOUT_ADDR = {REG_ERROR_TIMEOUT, 2'b00};

    // predicts the supervisor state and holds the result beats still owed
    class supervisor_scoreboard;
        logic [15:0] limit_reg;
        logic [7:0]  timeout_reg;
        logic [15:0] elapsed;
        bit          cycle_req;
        logic [7:0]  cycle_left;
        logic [7:0]  err_left;
        logic [7:0]  delay_secs;
        bit          shut_held;
        t_result     owed_results[$];
        int unsigned mismatches;
        int unsigned beats;
        int unsigned soft_resets;
        int unsigned limit_trips;
        int unsigned cycle_cmds;
        int unsigned shutdown_beats;

        function new();
            limit_reg   = MIN_LIMIT;
            timeout_reg = DEFAULT_TIMEOUT;
            restore_defaults();
        endfunction

        // soft reset: state only, registers keep their values
        function void restore_defaults();
            elapsed    = '0;
            cycle_req  = 1'b0;
            cycle_left = '0;
            err_left   = timeout_reg;
            delay_secs = DEFAULT_DELAY;
            shut_held  = 1'b0;
        endfunction

        function void write_reg(logic sel, logic [31:0] data);
            if (sel == REG_ELAPSED_LIMIT)
                limit_reg = data[15:0];
            else
                timeout_reg = data[7:0];
        endfunction

        // one-second tick: limit check, countdown, then bus-error countdown
        function bit advance_second(bit err);
            logic [15:0] eff_limit;
            eff_limit = (limit_reg < MIN_LIMIT) ? MIN_LIMIT : limit_reg;
            if (elapsed >= eff_limit) begin
                cycle_req  = 1'b1;
                cycle_left = '0;
                limit_trips++;
            end else if (elapsed != 16'hFFFF) begin
                elapsed = elapsed + 16'd1;
            end
            if (cycle_req) begin
                if (cycle_left != 0)
                    cycle_left = cycle_left - 8'd1;
                else
                    shut_held = 1'b1;
            end
            if (err) begin
                if (err_left != 0)
                    err_left = err_left - 8'd1;
                return err_left == 0;
            end
            err_left = timeout_reg;
            return 1'b0;
        endfunction

        function void note_beat(t_item it);
            t_result want;
            bit fire;
            fire = 1'b0;
            case (it.kind)
                KIND_TICK: fire = advance_second(it.bus_error);
                KIND_CMD: begin
                    if (it.value == CMD_CLEAR) begin
                        elapsed = '0;
                    end else if (it.value == CMD_RESET) begin
                        fire = 1'b1;
                    end else if (it.value == CMD_CYCLE) begin
                        cycle_req  = 1'b1;
                        cycle_left = delay_secs;
                        cycle_cmds++;
                    end
                end
                KIND_DELAY: delay_secs = (it.value > 16'd255) ? DELAY_MAX : it.value[7:0];
                default: elapsed = it.value;
            endcase
            if (fire) begin
                restore_defaults();
                soft_resets++;
            end
            want.shutdown        = shut_held;
            want.soft_reset      = fire;
            want.elapsed_now     = elapsed;
            want.cycle_pending   = cycle_req;
            want.cycle_remaining = cycle_left;
            if (shut_held)
                shutdown_beats++;
            beats++;
            owed_results.push_back(want);
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("shutdown", want.shutdown, got.shutdown);
            compare_field("soft_reset", want.soft_reset, got.soft_reset);
            compare_field("elapsed_now", want.elapsed_now, got.elapsed_now);
            compare_field("cycle_pending", want.cycle_pending, got.cycle_pending);
            compare_field("cycle_remaining", want.cycle_remaining, got.cycle_remaining);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hwpc_in_if  item_if ();
    hwpc_out_if result_if ();

    host_watchdog_power_cycler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_if),
        .o_result (result_if)
    );

    supervisor_scoreboard sb;
    bit          steady;
    int unsigned beats_sent;
    int          err_run;
    logic [15:0] cur_limit;
    logic [7:0]  cur_timeout;
    int          idle_cycles;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hang detection: cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result sink with random back-pressure
    initial begin
        t_result got;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                got.shutdown        = result_if.shutdown;
                got.soft_reset      = result_if.soft_reset;
                got.elapsed_now     = result_if.elapsed_now;
                got.cycle_pending   = result_if.cycle_pending;
                got.cycle_remaining = result_if.cycle_remaining;
                sb.check_result(got);
            end
            @(negedge i_clk);
            result_if.ready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    function automatic t_item make_beat(t_kind k, logic [15:0] v, bit e);
        t_item it;
        it.kind      = k;
        it.value     = v;
        it.bus_error = e;
        return it;
    endfunction

    // random beat, weighted so that limit trips, countdowns and resets happen often
    function automatic t_item random_beat();
        t_item it;
        int pick;
        int sub;
        pick         = $urandom_range(0, 99);
        sub          = $urandom_range(0, 99);
        it.value     = 16'($urandom_range(0, 65535));
        it.bus_error = 1'($urandom_range(0, 1));
        if (pick < 55) begin
            it.kind = KIND_TICK;
            if (err_run == 0 && $urandom_range(0, 99) < 5)
                err_run = $urandom_range(1, int'(cur_timeout) + 2);
            if (err_run != 0) begin
                it.bus_error = 1'b1;
                err_run--;
            end else begin
                it.bus_error = ($urandom_range(0, 99) < 3);
            end
        end else if (pick < 67) begin
            it.kind = KIND_CMD;
            if (sub < 25)
                it.value = CMD_CLEAR;
            else if (sub < 35)
                it.value = CMD_RESET;
            else if (sub < 70)
                it.value = CMD_CYCLE;
            else if (sub < 85)
                it.value = CMD_CYCLE ^ (16'h0001 << $urandom_range(0, 15));
        end else if (pick < 77) begin
            it.kind = KIND_DELAY;
            if (sub < 85)
                it.value = 16'($urandom_range(0, 12));
        end else begin
            it.kind = KIND_COUNT;
            if (sub < 60)
                it.value = 16'(int'(cur_limit) - $urandom_range(0, 6));
            else if (sub < 80)
                it.value = (cur_limit > 16'd65529) ? 16'hFFFF
                                                   : 16'(int'(cur_limit) + $urandom_range(0, 6));
        end
        return it;
    endfunction

    // drive one beat from a falling edge and return at the falling edge after acceptance
    task automatic send_beat(input t_item it);
        if (!steady && $urandom_range(0, 99) < 11) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.kind      <= it.kind;
        item_if.value     <= it.value;
        item_if.bus_error <= it.bus_error;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        sb.note_beat(it);
        beats_sent++;
        steady = (beats_sent >= 450 && beats_sent < 650);
        @(negedge i_clk);
    endtask

    // hold the sender off until every owed result has arrived
    task automatic wait_for_results();
        item_if.valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(negedge i_clk);
    endtask

    // setup and access phase, then idle before the next transfer
    task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.write_reg(addr[2], data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [15:0] limit_plan [NUM_PHASES];
        logic [7:0]  timeout_plan [NUM_PHASES];
        sb = new();
        limit_plan   = '{16'd300, 16'd0, 16'hFFFF, 16'd310, 16'd305, 16'd299, 16'd0, 16'd300};
        timeout_plan = '{8'd30, 8'd1, 8'd255, 8'd0, 8'd4, 8'd30, 8'd0, 8'd2};
        limit_plan[6]   = 16'($urandom_range(300, 420));
        timeout_plan[6] = 8'($urandom_range(1, 8));
        steady      = 1'b0;
        beats_sent  = 0;
        err_run     = 0;
        idle_cycles = 0;
        cur_limit   = MIN_LIMIT;
        cur_timeout = DEFAULT_TIMEOUT;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_if.valid     = 1'b0;
        item_if.kind      = KIND_TICK;
        item_if.value     = '0;
        item_if.bus_error = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: commands, unknown codes, delay saturation, repeat cycle, limit trip
        send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'hFFFF, 1'b1));
        send_beat(make_beat(KIND_CMD, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_CLEAR | 16'h0100, 1'b1));
        send_beat(make_beat(KIND_CMD, CMD_CYCLE | 16'h8000, 1'b0));
        send_beat(make_beat(KIND_DELAY, 16'h1234, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_CYCLE, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'h5A5A, 1'b0));
        send_beat(make_beat(KIND_DELAY, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_CYCLE, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'hA5A5, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_CLEAR, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_RESET, 1'b0));
        send_beat(make_beat(KIND_COUNT, 16'd299, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_COUNT, 16'hFFFF, 1'b0));
        send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
        send_beat(make_beat(KIND_CMD, CMD_RESET, 1'b0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // registers change only with the pipeline empty
            if (ph != 0) begin
                wait_for_results();
                repeat (2) @(negedge i_clk);
                apb_write(LIMIT_ADDR, {16'($urandom_range(0, 65535)), limit_plan[ph]});
                apb_write(TIMEOUT_ADDR, {24'($urandom_range(0, 16777215)), timeout_plan[ph]});
                cur_limit   = (limit_plan[ph] < MIN_LIMIT) ? MIN_LIMIT : limit_plan[ph];
                cur_timeout = timeout_plan[ph];
                err_run     = 0;
            end
            // directed beats for the corner settings
            case (ph)
                1: begin
                    // limit below the floor, a single errored tick resets
                    send_beat(make_beat(KIND_COUNT, 16'd299, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b1));
                end
                2: begin
                    // counter at its top with the widest limit
                    send_beat(make_beat(KIND_COUNT, 16'hFFFE, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
                end
                3: begin
                    // zero timeout: first errored tick resets
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b0));
                    send_beat(make_beat(KIND_TICK, 16'h0000, 1'b1));
                end
                default: ;
            endcase
            for (int n = 0; n < RANDOM_BEATS; n++) begin
                if ($urandom_range(0, 149) == 0)
                    wait_for_results();
                send_beat(random_beat());
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("covered %0d beats over %0d register settings, with %0d soft resets,",
                 sb.beats, NUM_PHASES, sb.soft_resets);
        $display("%0d limit trips, %0d delayed cycle requests, %0d beats with shutdown held",
                 sb.limit_trips, sb.cycle_cmds, sb.shutdown_beats);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
